[hw/rtl/biq_pkg.sv]
// ----------------------------------------------------------------------------
// biq_pkg: shared types and constants of the biquad filter
// Coefficient format, register indexes, sequencer states and the control
// struct that drives the shared datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package biq_pkg;

    localparam int COEF_W         = 18;
    localparam int COEF_FRAC_BITS = 14;
    // Headroom of the accumulator above the sample width: five products of
    // COEF_W x SAMPLE_WIDTH bits summed.
    localparam int ACC_EXTRA      = 20;
    localparam int CFG_IDX_W      = 3;
    localparam int MAC_TAPS       = 5;
    localparam int MAC_CNT_W      = 3;

    localparam logic [COEF_W-1:0] COEF_UNITY = COEF_W'(1 << COEF_FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE = 3'd0,
        REG_B0     = 3'd1,
        REG_B1     = 3'd2,
        REG_B2     = 3'd3,
        REG_A0     = 3'd4,
        REG_A1     = 3'd5,
        REG_A2     = 3'd6
    } cfg_reg_t;

    typedef enum logic [MAC_CNT_W-1:0] {
        TAP_B0 = 3'd0,
        TAP_B1 = 3'd1,
        TAP_B2 = 3'd2,
        TAP_A1 = 3'd3,
        TAP_A2 = 3'd4
    } tap_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MAC  = 6'b000010,
        ST_ABS  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_FIX  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    // Datapath commands from the sequencer
    typedef struct packed {
        logic start;
        logic mul_en;
        tap_t tap;
        logic acc_en;
        logic abs_load;
        logic div_step;
        logic fix;
    } dp_ctrl_t;

    // Sequencer status toward the top level
    typedef struct packed {
        logic ready;
        logic load_out;
        logic filt;
    } seq_stat_t;

endpackage

`default_nettype wire

[hw/rtl/biq_if.sv]
// ----------------------------------------------------------------------------
// biq_if: valid/ready channels of the biquad filter
// Sample input channel, result output channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface biq_in_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           frame_last_in;

    modport source (output valid, output sample_in, output frame_last_in, input ready);
    modport sink   (input valid, input sample_in, input frame_last_in, output ready);
endinterface

interface biq_out_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           saturated;
    logic                           frame_last_out;

    modport source (output valid, output sample_out, output saturated,
                    output frame_last_out, input ready);
    modport sink   (input valid, input sample_out, input saturated,
                    input frame_last_out, output ready);
endinterface

interface biq_cfg_if
    import biq_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COEF_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/biquad_iir_filter_top.sv]
// ----------------------------------------------------------------------------
// biquad_iir_filter_top: direct form I biquad section, one sample at a time
// Filter on: each input beat runs the MAC steps, the magnitude step, the
//   restoring divider (one quotient bit per cycle) and the sign fix before the
//   result is registered; a new sample is taken only once that result is loaded.
// Zero a0: the divide and sign fix are skipped. Bypass: the sample is copied to
//   the output register directly.
// Reset (rst_n, async low) clears history, enable, b0/a0 to 1.0, rest to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_iir_filter_top
    import biq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24
) (
    input wire logic  clk,
    input wire logic  rst_n,
    biq_cfg_if.sink   cfg,
    biq_in_if.sink    sample_chan,
    biq_out_if.source result_chan
);

    // Configuration registers
    logic                     enable_reg;
    logic signed [COEF_W-1:0] b0_reg, b1_reg, b2_reg;
    logic signed [COEF_W-1:0] a0_reg, a1_reg, a2_reg;

    // Current sample and filter history
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic                           last_reg;
    logic signed [SAMPLE_WIDTH-1:0] x1_reg, x2_reg, y1_reg, y2_reg;

    // Output register; decouples the result beat from the next input beat
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic                           out_sat_reg;
    logic                           out_last_reg;

    dp_ctrl_t                       ctrl;
    seq_stat_t                      seq_st;
    logic                           a0_zero;
    logic signed [SAMPLE_WIDTH-1:0] dp_y;
    logic                           dp_sat;
    logic                           in_fire;
    logic                           out_free;

    assign cfg.ready         = 1'b1;
    assign sample_chan.ready = seq_st.ready;
    assign in_fire           = sample_chan.valid & seq_st.ready;
    assign out_free          = ~out_valid_reg | result_chan.ready;

    // Register writes; indexes past the last register are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            b0_reg     <= COEF_UNITY;
            b1_reg     <= '0;
            b2_reg     <= '0;
            a0_reg     <= COEF_UNITY;
            a1_reg     <= '0;
            a2_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_ENABLE: enable_reg <= cfg.data[0];
                REG_B0:     b0_reg     <= cfg.data;
                REG_B1:     b1_reg     <= cfg.data;
                REG_B2:     b2_reg     <= cfg.data;
                REG_A0:     a0_reg     <= cfg.data;
                REG_A1:     a1_reg     <= cfg.data;
                REG_A2:     a2_reg     <= cfg.data;
                default:    ;
            endcase
        end
    end

    // Sample capture on the input beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg    <= sample_chan.sample_in;
            last_reg <= sample_chan.frame_last_in;
        end
    end

    // History shifts only for filtered samples, with the clipped output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else if (seq_st.load_out && seq_st.filt)
        begin
            x2_reg <= x1_reg;
            x1_reg <= x_reg;
            y2_reg <= y1_reg;
            y1_reg <= dp_y;
        end
    end

    // Result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (seq_st.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_chan.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_st.load_out)
        begin
            out_sample_reg <= seq_st.filt ? dp_y : x_reg;
            out_sat_reg    <= seq_st.filt & dp_sat;
            out_last_reg   <= last_reg;
        end
    end

    assign result_chan.valid          = out_valid_reg;
    assign result_chan.sample_out     = out_sample_reg;
    assign result_chan.saturated      = out_sat_reg;
    assign result_chan.frame_last_out = out_last_reg;

    biq_seq #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_chan.valid),
        .enable   (enable_reg),
        .a0_zero  (a0_zero),
        .out_free (out_free),
        .ctrl     (ctrl),
        .stat     (seq_st)
    );

    biq_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .clk     (clk),
        .ctrl    (ctrl),
        .x       (x_reg),
        .x1      (x1_reg),
        .x2      (x2_reg),
        .y1      (y1_reg),
        .y2      (y2_reg),
        .b0      (b0_reg),
        .b1      (b1_reg),
        .b2      (b2_reg),
        .a0      (a0_reg),
        .a1      (a1_reg),
        .a2      (a2_reg),
        .a0_zero (a0_zero),
        .y       (dp_y),
        .sat     (dp_sat)
    );

endmodule

`default_nettype wire

[hw/rtl/biq_dp.sv]
// ----------------------------------------------------------------------------
// biq_dp: shared multiply/add datapath
// One multiplier and one add/sub unit serve the five MAC steps, the magnitude
// conversion, the restoring divide steps and the final sign fix.
// ----------------------------------------------------------------------------
`default_nettype none

module biq_dp
    import biq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                           clk,
    input  wire dp_ctrl_t                       ctrl,
    input  wire logic signed [SAMPLE_WIDTH-1:0] x,
    input  wire logic signed [SAMPLE_WIDTH-1:0] x1,
    input  wire logic signed [SAMPLE_WIDTH-1:0] x2,
    input  wire logic signed [SAMPLE_WIDTH-1:0] y1,
    input  wire logic signed [SAMPLE_WIDTH-1:0] y2,
    input  wire logic signed [COEF_W-1:0]       b0,
    input  wire logic signed [COEF_W-1:0]       b1,
    input  wire logic signed [COEF_W-1:0]       b2,
    input  wire logic signed [COEF_W-1:0]       a0,
    input  wire logic signed [COEF_W-1:0]       a1,
    input  wire logic signed [COEF_W-1:0]       a2,
    output logic                                a0_zero,
    output logic signed [SAMPLE_WIDTH-1:0]      y,
    output logic                                sat
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int ACC_W  = SW + ACC_EXTRA;
    localparam int PROD_W = SW + COEF_W;
    localparam int REM_W  = COEF_W;
    localparam logic [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

    logic signed [COEF_W-1:0] m_coef;
    logic signed [SW-1:0]     m_samp;
    logic                     m_sub;
    logic signed [PROD_W-1:0] prod_full;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_sub_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]         quo_reg;
    logic [REM_W-1:0]         rem_reg;
    logic                     neg_reg;
    logic signed [SW-1:0]     y_reg;
    logic                     sat_reg;

    logic [COEF_W-1:0]        a0_u;
    logic [COEF_W-1:0]        a0_mag;
    logic signed [ACC_W-1:0]  add_a;
    logic signed [ACC_W-1:0]  add_b;
    logic                     add_sub;
    logic signed [ACC_W-1:0]  add_sum;
    logic                     trial_ok;
    logic [ACC_W-SW:0]        hi_bits;
    logic                     in_range;

    assign a0_zero = (a0 == '0);
    assign a0_u    = $unsigned(a0);
    assign a0_mag  = a0_u[COEF_W-1] ? (~a0_u + COEF_W'(1)) : a0_u;

    // Tap select for the multiplier; feedback taps are subtracted
    always_comb
    begin
        m_coef = b0;
        m_samp = x;
        m_sub  = 1'b0;
        case (ctrl.tap)
            TAP_B0:
            begin
                m_coef = b0;
                m_samp = x;
            end
            TAP_B1:
            begin
                m_coef = b1;
                m_samp = x1;
            end
            TAP_B2:
            begin
                m_coef = b2;
                m_samp = x2;
            end
            TAP_A1:
            begin
                m_coef = a1;
                m_samp = y1;
                m_sub  = 1'b1;
            end
            TAP_A2:
            begin
                m_coef = a2;
                m_samp = y2;
                m_sub  = 1'b1;
            end
            default:
            begin
                m_coef = b0;
                m_samp = x;
            end
        endcase
    end

    assign prod_full = m_coef * m_samp;

    // Shared add/sub unit operand steering
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        if (ctrl.acc_en)
        begin
            add_a   = acc_reg;
            add_b   = ACC_W'(prod_reg);
            add_sub = prod_sub_reg;
        end
        else if (ctrl.abs_load)
        begin
            add_b   = acc_reg;
            add_sub = acc_reg[ACC_W-1];
        end
        else if (ctrl.div_step)
        begin
            add_a   = ACC_W'({rem_reg, quo_reg[ACC_W-1]});
            add_b   = ACC_W'(a0_mag);
            add_sub = 1'b1;
        end
        else if (ctrl.fix)
        begin
            add_b   = quo_reg;
            add_sub = neg_reg;
        end
    end

    assign add_sum  = add_sub ? (add_a - add_b) : (add_a + add_b);
    assign trial_ok = ~add_sum[ACC_W-1];
    assign hi_bits  = add_sum[ACC_W-1:SW-1];
    assign in_range = (&hi_bits) | ~(|hi_bits);

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            acc_reg <= '0;
        end
        if (ctrl.mul_en)
        begin
            prod_reg     <= prod_full;
            prod_sub_reg <= m_sub;
        end
        if (ctrl.acc_en)
        begin
            acc_reg <= add_sum;
        end
        if (ctrl.abs_load)
        begin
            quo_reg <= add_sum;
            rem_reg <= '0;
            neg_reg <= acc_reg[ACC_W-1] ^ a0[COEF_W-1];
            // zero divisor: clip toward the sign of the sum
            y_reg   <= acc_reg[ACC_W-1] ? SMIN : SMAX;
            sat_reg <= 1'b1;
        end
        if (ctrl.div_step)
        begin
            rem_reg <= trial_ok ? add_sum[REM_W-1:0] : {rem_reg[REM_W-2:0], quo_reg[ACC_W-1]};
            quo_reg <= {quo_reg[ACC_W-2:0], trial_ok};
        end
        if (ctrl.fix)
        begin
            if (in_range)
            begin
                y_reg   <= add_sum[SW-1:0];
                sat_reg <= 1'b0;
            end
            else
            begin
                y_reg   <= add_sum[ACC_W-1] ? SMIN : SMAX;
                sat_reg <= 1'b1;
            end
        end
    end

    assign y   = y_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

[hw/rtl/biq_seq.sv]
// ----------------------------------------------------------------------------
// biq_seq: sample sequencer
// Steps the shared datapath through MAC, magnitude, divide and sign fix.
// ----------------------------------------------------------------------------
`default_nettype none

module biq_seq
    import biq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic enable,
    input  wire logic a0_zero,
    input  wire logic out_free,
    output dp_ctrl_t  ctrl,
    output seq_stat_t stat
);

    localparam int ACC_W     = SAMPLE_WIDTH + ACC_EXTRA;
    localparam int DIV_CNT_W = $clog2(ACC_W);

    state_t               state_reg, state_next;
    logic [MAC_CNT_W-1:0] mac_cnt_reg, mac_cnt_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 filt_reg, filt_next;

    always_comb
    begin
        state_next    = state_reg;
        mac_cnt_next  = mac_cnt_reg;
        div_cnt_next  = div_cnt_reg;
        filt_next     = filt_reg;
        ctrl          = '0;
        ctrl.tap      = TAP_B0;
        stat.ready    = 1'b0;
        stat.load_out = 1'b0;
        stat.filt     = filt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                stat.ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.start   = 1'b1;
                    filt_next    = enable;
                    mac_cnt_next = '0;
                    state_next   = enable ? ST_MAC : ST_DONE;
                end
            end
            ST_MAC:
            begin
                // product of tap n is summed while tap n+1 multiplies
                ctrl.acc_en = (mac_cnt_reg != '0);
                if (mac_cnt_reg < MAC_CNT_W'(MAC_TAPS))
                begin
                    ctrl.mul_en = 1'b1;
                    ctrl.tap    = tap_t'(mac_cnt_reg);
                end
                if (mac_cnt_reg == MAC_CNT_W'(MAC_TAPS))
                begin
                    state_next = ST_ABS;
                end
                else
                begin
                    mac_cnt_next = mac_cnt_reg + MAC_CNT_W'(1);
                end
            end
            ST_ABS:
            begin
                ctrl.abs_load = 1'b1;
                div_cnt_next  = '0;
                state_next    = a0_zero ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(ACC_W - 1))
                begin
                    state_next = ST_FIX;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                end
            end
            ST_FIX:
            begin
                ctrl.fix   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    stat.load_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mac_cnt_reg <= '0;
            div_cnt_reg <= '0;
            filt_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mac_cnt_reg <= mac_cnt_next;
            div_cnt_reg <= div_cnt_next;
            filt_reg    <= filt_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/biq_checker.sv]
// ----------------------------------------------------------------------------
// biq_checker: port-level checks of the biquad filter
// Result beat holding, busy after an input beat, clipped values at the rails.
// ----------------------------------------------------------------------------
`default_nettype none

module biq_checker #(
    parameter int SAMPLE_WIDTH = 24
) (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic [SAMPLE_WIDTH-1:0] sample_out,
    input wire logic                    saturated,
    input wire logic                    frame_last_out
);

    localparam logic [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(sample_out) && $stable(saturated) && $stable(frame_last_out))
        else $error("result payload changed while stalled");

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready after input beat while sample in flight");

    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> sample_out == SMAX || sample_out == SMIN)
        else $error("saturated result not at a rail");

endmodule

bind biquad_iir_filter_top biq_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_biq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (sample_chan.valid),
    .in_ready       (sample_chan.ready),
    .out_valid      (result_chan.valid),
    .out_ready      (result_chan.ready),
    .sample_out     (result_chan.sample_out),
    .saturated      (result_chan.saturated),
    .frame_last_out (result_chan.frame_last_out)
);

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the direct form I biquad section
// Drives random-timed sample beats and coefficient writes, predicts every
// result beat in-bench with a 64-bit exact model of the filter, and checks
// the result stream beat by beat against it.
// ----------------------------------------------------------------------------

module testbench;

    import biq_pkg::*;

    localparam int SW          = 24;
    localparam int CLK_HALF    = 10;
    localparam int RST_CYCLES  = 10;
    // Watchdog bound in cycles, well above the slowest run of about 600 beats
    // with compute, receiver stalls and sender gaps.
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_LEN    = 400;           // long receiver hold-off
    localparam int SETTLE      = 4;             // pause before a config write
    localparam int DRAIN       = 2 * (SW + 30); // quiet time at the end
    localparam int SEG_BEATS   = 110;           // beats per random segment
    localparam int MAX_PRINTS  = 50;
    localparam int NUM_REGS    = REG_A2 + 1;

    // Index 7 is not mapped; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam longint S_MAX = (longint'(1) << (SW - 1)) - 1;
    localparam longint S_MIN = -S_MAX - 1;
    localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic                 last;
    } sample_beat_t;

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic                 sat;
        logic                 last;
    } result_beat_t;

    // Coefficient mixes for the random segments
    typedef enum {
        MIX_STABLE,
        MIX_WILD,
        MIX_TINY_A0,
        MIX_BYPASS,
        MIX_EXTREME
    } coef_mix_t;

    logic clk;
    logic rst_n;

    biq_in_if  #(.SAMPLE_WIDTH(SW)) sample_chan ();
    biq_out_if #(.SAMPLE_WIDTH(SW)) result_chan ();
    biq_cfg_if                      cfg_chan ();

    biquad_iir_filter_top #(.SAMPLE_WIDTH(SW)) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_chan),
        .sample_chan (sample_chan),
        .result_chan (result_chan)
    );

    // ------------------------------------------------------------------
    // In-bench copy of the filter: configuration and history
    // ------------------------------------------------------------------
    logic                     flt_en;
    logic signed [COEF_W-1:0] c_b0, c_b1, c_b2, c_a0, c_a1, c_a2;
    logic signed [SW-1:0]     hx1, hx2, hy1, hy2;

    sample_beat_t sample_backlog [$];   // beats waiting to be offered
    result_beat_t results_owed   [$];   // predicted results, oldest first

    int  err_cnt   = 0;
    int  res_cnt   = 0;
    int  cycle_cnt = 0;
    int  hold_asks = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  in_gap    = 0;
    int  out_gap   = 0;
    bit  in_idle_on  = 0;
    bit  out_idle_on = 0;
    logic in_taken;
    sample_beat_t next_beat;

    // Sum of products over the exact 64-bit range, then divide by a0
    // (truncating toward zero) and clip to the sample range.
    function automatic result_beat_t compute_biquad_output(sample_beat_t b);
        longint       acc;
        longint       q;
        result_beat_t r;
        r.last = b.last;
        r.sat  = 1'b0;
        if (!flt_en) begin
            // bypass: copy through, history untouched
            r.sample = b.sample;
        end
        else begin
            acc = longint'(c_b0) * longint'(b.sample)
                + longint'(c_b1) * longint'(hx1)
                + longint'(c_b2) * longint'(hx2)
                - longint'(c_a1) * longint'(hy1)
                - longint'(c_a2) * longint'(hy2);
            if (c_a0 == '0) begin
                // zero divisor: rail by the sign of the sum
                r.sample = (acc < 0) ? SW'(S_MIN) : SW'(S_MAX);
                r.sat    = 1'b1;
            end
            else begin
                q = acc / longint'(c_a0);
                if (q > S_MAX) begin
                    r.sample = SW'(S_MAX);
                    r.sat    = 1'b1;
                end
                else if (q < S_MIN) begin
                    r.sample = SW'(S_MIN);
                    r.sat    = 1'b1;
                end
                else begin
                    r.sample = SW'(q);
                end
            end
            hx2 = hx1;
            hx1 = b.sample;
            hy2 = hy1;
            hy1 = r.sample;
        end
        return r;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
        case (idx)
            REG_ENABLE: flt_en = val[0];
            REG_B0:     c_b0   = val;
            REG_B1:     c_b1   = val;
            REG_B2:     c_b2   = val;
            REG_A0:     c_a0   = val;
            REG_A1:     c_a1   = val;
            REG_A2:     c_a2   = val;
            default:    ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
            $display("ERROR beat %0d %s: got %0d, expected %0d", res_cnt, what, got, want);
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [SW-1:0] pick_sample();
        int r;
        int v;
        r = $urandom_range(0, 9);
        case (r)
            0: return SW'(S_MAX);
            1: return SW'(S_MIN);
            2, 3, 4:
            begin
                v = $urandom_range(0, 2000);
                return SW'(v - 1000);
            end
            default: return SW'($urandom());
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] coef_in(int lo, int hi);
        int v;
        v = $urandom_range(0, hi - lo);
        return COEF_W'(v + lo);
    endfunction

    function automatic logic [COEF_W-1:0] coef_rail();
        return ($urandom_range(0, 1) != 0) ? COEF_MAX : COEF_MIN;
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles, %0d results outstanding",
                     cycle_cnt, results_owed.size());
            $display("biquad_iir_filter_top verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sample driver: offers backlog beats at the falling edge, holds a
    // beat until it is taken, optional random gap after each beat.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            sample_chan.valid <= 1'b0;
            in_gap = 0;
        end
        else if (!sample_chan.valid || in_taken)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                sample_chan.valid <= 1'b0;
            end
            else if (sample_backlog.size() > 0)
            begin
                next_beat = sample_backlog.pop_front();
                sample_chan.sample_in     <= next_beat.sample;
                sample_chan.frame_last_in <= next_beat.last;
                sample_chan.valid         <= 1'b1;
                if (in_idle_on)
                    in_gap = pick_gap();
            end
            else
            begin
                sample_chan.valid <= 1'b0;
            end
        end
    end

    // Long hold-off of the result side, counted here in cycles
    always @(negedge clk)
    begin
        if (hold_seen != hold_asks)
        begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_LEN;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Result-side ready: random stalls, forced low during a hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            result_chan.ready <= 1'b0;
        else if (hold_left > 0)
            result_chan.ready <= 1'b0;
        else if (out_gap > 0)
        begin
            out_gap--;
            result_chan.ready <= 1'b0;
        end
        else
        begin
            result_chan.ready <= 1'b1;
            if (out_idle_on && $urandom_range(0, 3) == 0)
                out_gap = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted sample beat, checks every
    // accepted result beat against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= sample_chan.valid && sample_chan.ready;
            if (sample_chan.valid && sample_chan.ready)
                results_owed.push_back(compute_biquad_output(
                    '{sample: sample_chan.sample_in, last: sample_chan.frame_last_in}));
            if (result_chan.valid && result_chan.ready)
            begin
                if (results_owed.size() == 0)
                begin
                    report_mismatch("unexpected result, sample_out",
                                    longint'(result_chan.sample_out), 0);
                end
                else
                begin
                    automatic result_beat_t want = results_owed.pop_front();
                    if (result_chan.sample_out !== want.sample)
                        report_mismatch("sample_out", longint'(result_chan.sample_out),
                                        longint'(want.sample));
                    if (result_chan.saturated !== want.sat)
                        report_mismatch("saturated", longint'(result_chan.saturated),
                                        longint'(want.sat));
                    if (result_chan.frame_last_out !== want.last)
                        report_mismatch("frame_last_out", longint'(result_chan.frame_last_out),
                                        longint'(want.last));
                end
                res_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------
    task automatic push_sample(input longint v, input logic last);
        sample_backlog.push_back('{sample: SW'(v), last: last});
    endtask

    // Block is idle once every beat is in and every result is out
    task automatic wait_idle();
        while (sample_backlog.size() != 0 || sample_chan.valid || results_owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(negedge clk);
        cfg_chan.index <= idx;
        cfg_chan.data  <= val;
        cfg_chan.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_chan.ready)
            @(posedge clk);
        apply_reg(idx, val);
        @(negedge clk);
        cfg_chan.valid <= 1'b0;
    endtask

    // Writes every register with a setting drawn from the given mix
    task automatic load_mix(input coef_mix_t mix);
        logic [COEF_W-1:0] k [NUM_REGS];
        foreach (k[i])
            k[i] = COEF_W'($urandom());
        k[REG_ENABLE] = COEF_W'(1);
        case (mix)
            MIX_STABLE:
            begin
                k[REG_B0] = coef_in(-8192, 8192);
                k[REG_B1] = coef_in(-8192, 8192);
                k[REG_B2] = coef_in(-8192, 8192);
                k[REG_A0] = COEF_UNITY;
                k[REG_A1] = coef_in(-20000, 20000);
                k[REG_A2] = coef_in(-12000, 12000);
            end
            MIX_TINY_A0:
            begin
                k[REG_B0] = coef_in(-4096, 4096);
                k[REG_B1] = coef_in(-4096, 4096);
                k[REG_B2] = coef_in(-4096, 4096);
                k[REG_A0] = coef_in(-4, 4);     // zero included
                k[REG_A1] = coef_in(-2000, 2000);
                k[REG_A2] = coef_in(-2000, 2000);
            end
            MIX_BYPASS:  k[REG_ENABLE] = '0;
            MIX_EXTREME:
            begin
                for (int i = REG_B0; i < NUM_REGS; i++)
                    k[i] = coef_rail();
            end
            default: ;  // wild: fully random coefficients
        endcase
        foreach (k[i])
            write_reg(CFG_IDX_W'(i), k[i]);
        write_reg(REG_UNUSED, COEF_W'($urandom()));
    endtask

    initial
    begin
        coef_mix_t seg_mix [5];

        // everything known from time zero
        rst_n                     = 1'b0;
        sample_chan.valid         = 1'b0;
        sample_chan.sample_in     = '0;
        sample_chan.frame_last_in = 1'b0;
        result_chan.ready         = 1'b0;
        cfg_chan.valid            = 1'b0;
        cfg_chan.index            = REG_ENABLE;
        cfg_chan.data             = '0;
        in_taken                  = 1'b0;

        // predictor at its reset state
        flt_en = 1'b0;
        c_b0   = COEF_UNITY;
        c_b1   = '0;
        c_b2   = '0;
        c_a0   = COEF_UNITY;
        c_a1   = '0;
        c_a2   = '0;
        hx1    = '0;
        hx2    = '0;
        hy1    = '0;
        hy2    = '0;

        repeat (RST_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed ----
        // bypass straight out of reset, sample extremes and marker both ways
        push_sample(S_MAX, 1'b1);
        push_sample(S_MIN, 1'b0);
        push_sample(0, 1'b0);
        push_sample(-1, 1'b1);
        wait_idle();

        // filter on with reset coefficients: unity pass
        write_reg(REG_ENABLE, COEF_W'(1));
        push_sample(S_MAX, 1'b0);
        push_sample(S_MIN, 1'b1);
        push_sample(12345, 1'b0);
        wait_idle();

        // largest b0: clips at both rails
        write_reg(REG_B0, COEF_MAX);
        push_sample(S_MAX, 1'b0);
        push_sample(S_MIN, 1'b0);
        wait_idle();

        // zero divisor: negative, positive and zero sums
        write_reg(REG_A0, '0);
        push_sample(-100, 1'b0);
        push_sample(100, 1'b1);
        push_sample(0, 1'b0);
        wait_idle();

        // all coefficients at their rails, negative divisor
        write_reg(REG_B0, COEF_MIN);
        write_reg(REG_B1, COEF_MIN);
        write_reg(REG_B2, COEF_MAX);
        write_reg(REG_A0, COEF_MIN);
        write_reg(REG_A1, COEF_MIN);
        write_reg(REG_A2, COEF_MAX);
        push_sample(1000, 1'b0);
        push_sample(-777, 1'b1);
        push_sample(S_MAX, 1'b0);
        push_sample(3, 1'b0);
        push_sample(-2, 1'b1);
        wait_idle();

        // bypass in between must leave the history alone; unmapped write dropped
        write_reg(REG_ENABLE, '0);
        push_sample(4242, 1'b0);
        push_sample(-4242, 1'b1);
        wait_idle();
        write_reg(REG_UNUSED, COEF_MAX);
        write_reg(REG_ENABLE, COEF_W'(1));
        push_sample(500, 1'b0);
        push_sample(-500, 1'b0);
        wait_idle();

        // ---- random segments ----
        seg_mix = '{MIX_STABLE, MIX_WILD, MIX_TINY_A0, MIX_BYPASS, MIX_EXTREME};
        foreach (seg_mix[s])
        begin
            load_mix(seg_mix[s]);
            // idling per segment; one segment runs flat out on both sides
            in_idle_on  = (s == 0) || (s == 2) || (s == 4);
            out_idle_on = (s == 0) || (s == 3) || (s == 4);
            for (int n = 0; n < SEG_BEATS; n++)
                push_sample(pick_sample(), logic'($urandom_range(0, 1)));
            // back-pressure: the sender keeps offering while a held result stalls the filter
            if (s == 0)
                hold_asks++;
            wait_idle();
        end

        repeat (DRAIN) @(posedge clk);

        if (err_cnt == 0)
            $display("biquad_iir_filter_top verification clean");
        else
            $display("biquad_iir_filter_top verification failed");
        $finish;
    end

endmodule
